// ===== src/crsd_pkg.sv =====
`default_nettype none

package crsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_ABORT  = 2'd2;

  // Register word indexes
  localparam logic REG_HEADER_SKIP = 1'b0;

  localparam logic [7:0] HEADER_SKIP_RST = 8'd48;
  localparam int         ID_W            = 29;
  localparam int         EXT_BIT         = 31;
  localparam logic [2:0] HDR_LAST_POS    = 3'd7;

  // Record header fields shared by every result of a record
  typedef struct packed {
    logic [ID_W-1:0] frame_id;
    logic            extended;
    logic [3:0]      dlc;
    logic            brs;
    logic            esi;
    logic            fd_format;
    logic            channel;
  } rec_hdr_t;

  // One queued entry: a primary result plus an optional trailing abort
  typedef struct packed {
    rec_hdr_t   hdr;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       last;
    logic       abort;
    logic [7:0] abort_index;
  } out_entry_t;

  // Record length rounded up to a CAN FD DLC, saturating at 15
  function automatic logic [3:0] len_to_dlc(input logic [7:0] len);
    logic [3:0] d;
    if (len <= 8'd8)       d = len[3:0];
    else if (len <= 8'd12) d = 4'd9;
    else if (len <= 8'd16) d = 4'd10;
    else if (len <= 8'd20) d = 4'd11;
    else if (len <= 8'd24) d = 4'd12;
    else if (len <= 8'd32) d = 4'd13;
    else if (len <= 8'd48) d = 4'd14;
    else                   d = 4'd15;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== src/can_record_stream_deframer.sv =====
`default_nettype none

// CAN record stream deframer. Takes one UDP payload byte per transfer, skips
// header_skip leading bytes (register at byte address 0, reset 48), then cuts
// the rest into CAN records of 8 header bytes plus "length" data bytes. Each
// kept record gives one header result and one result per data byte; a record
// cut short by the end of payload gets a trailing abort result. Records for a
// channel other than 0 or 1, or for a bus-off channel, are consumed silently.
// Every byte is parsed combinationally, and a byte is taken every cycle as long
// as results are drained at the same pace; a byte that yields two results
// (a result plus an abort) holds the queue head until both are taken. Results sit in
// a two-entry output queue, so in_ready depends only on queue occupancy.
module can_record_stream_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input byte stream
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_payload_byte,
  input  wire logic        in_last_of_payload,
  input  wire logic        in_bus_off_zero,
  input  wire logic        in_bus_off_one,
  // result stream
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_kind,
  output logic [28:0]      out_frame_id,
  output logic             out_extended,
  output logic [3:0]       out_dlc,
  output logic             out_brs,
  output logic             out_esi,
  output logic             out_fd_format,
  output logic             out_channel,
  output logic [7:0]       out_data_byte,
  output logic [7:0]       out_byte_index,
  output logic             out_last,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration register
  logic [7:0] header_skip_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_skip_r <= crsd_pkg::HEADER_SKIP_RST;
    end else if (psel && penable && pwrite && (paddr[2] == crsd_pkg::REG_HEADER_SKIP)) begin
      header_skip_r <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == crsd_pkg::REG_HEADER_SKIP) begin
      prdata = {24'd0, header_skip_r};
    end
  end

  // Parser state
  logic [7:0]  skip_count_r, skip_count_nxt;
  logic [2:0]  header_pos_r, header_pos_nxt;
  logic [55:0] header_bytes_r, header_bytes_nxt;
  logic [7:0]  data_left_r, data_left_nxt;
  logic [7:0]  data_pos_r, data_pos_nxt;
  logic        in_data_r, in_data_nxt;
  logic        dropped_r, dropped_nxt;

  logic [63:0]            hb_new;
  logic [7:0]             left_dec;
  logic [7:0]             rec_len;
  logic [7:0]             rec_chan;
  logic                   has_result;
  crsd_pkg::out_entry_t   new_entry;

  // Header fields of the current record, including the byte just taken
  always_comb begin
    hb_new = {8'd0, header_bytes_r};
    if (!(skip_count_r < header_skip_r) && !in_data_r) begin
      hb_new[{header_pos_r, 3'b000} +: 8] = in_payload_byte;
    end
  end

  assign rec_len  = hb_new[39:32];
  assign rec_chan = hb_new[55:48];
  assign left_dec = data_left_r - 8'd1;

  // Per-byte parse step
  always_comb begin
    skip_count_nxt   = skip_count_r;
    header_pos_nxt   = header_pos_r;
    header_bytes_nxt = hb_new[55:0];
    data_left_nxt    = data_left_r;
    data_pos_nxt     = data_pos_r;
    in_data_nxt      = in_data_r;
    dropped_nxt      = dropped_r;
    has_result       = 1'b0;

    new_entry.hdr.frame_id  = hb_new[crsd_pkg::ID_W-1:0];
    new_entry.hdr.extended  = hb_new[crsd_pkg::EXT_BIT];
    new_entry.hdr.dlc       = crsd_pkg::len_to_dlc(rec_len);
    new_entry.hdr.brs       = hb_new[40];
    new_entry.hdr.esi       = hb_new[41];
    new_entry.hdr.fd_format = hb_new[42];
    new_entry.hdr.channel   = hb_new[48];
    new_entry.kind          = crsd_pkg::KIND_HEADER;
    new_entry.data_byte     = 8'd0;
    new_entry.byte_index    = 8'd0;
    new_entry.last          = 1'b0;
    new_entry.abort         = 1'b0;
    new_entry.abort_index   = 8'd0;

    if (skip_count_r < header_skip_r) begin
      skip_count_nxt = skip_count_r + 8'd1;
    end else if (in_data_r) begin
      data_left_nxt          = left_dec;
      data_pos_nxt           = data_pos_r + 8'd1;
      in_data_nxt            = (left_dec != 8'd0);
      has_result             = !dropped_r;
      new_entry.kind         = crsd_pkg::KIND_DATA;
      new_entry.data_byte    = in_payload_byte;
      new_entry.byte_index   = data_pos_r;
      new_entry.last         = (left_dec == 8'd0);
      new_entry.abort        = in_last_of_payload && (left_dec != 8'd0);
      new_entry.abort_index  = data_pos_r + 8'd1;
    end else if (header_pos_r != crsd_pkg::HDR_LAST_POS) begin
      header_pos_nxt = header_pos_r + 3'd1;
    end else begin
      // Last header byte: decide whether the record is kept
      header_pos_nxt = 3'd0;
      if (rec_chan == 8'd0)      dropped_nxt = in_bus_off_zero;
      else if (rec_chan == 8'd1) dropped_nxt = in_bus_off_one;
      else                       dropped_nxt = 1'b1;
      data_left_nxt   = rec_len;
      data_pos_nxt    = 8'd0;
      in_data_nxt     = (rec_len != 8'd0);
      has_result      = !dropped_nxt;
      new_entry.last  = (rec_len == 8'd0);
      new_entry.abort = in_last_of_payload && (rec_len != 8'd0);
    end

    // End of payload returns the stream to its start
    if (in_last_of_payload) begin
      skip_count_nxt = 8'd0;
      header_pos_nxt = 3'd0;
      data_left_nxt  = 8'd0;
      data_pos_nxt   = 8'd0;
      in_data_nxt    = 1'b0;
      dropped_nxt    = 1'b0;
    end
  end

  logic in_xfer;
  assign in_xfer = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_count_r <= 8'd0;
      header_pos_r <= 3'd0;
      data_left_r  <= 8'd0;
      data_pos_r   <= 8'd0;
      in_data_r    <= 1'b0;
      dropped_r    <= 1'b0;
    end else if (in_xfer) begin
      skip_count_r <= skip_count_nxt;
      header_pos_r <= header_pos_nxt;
      data_left_r  <= data_left_nxt;
      data_pos_r   <= data_pos_nxt;
      in_data_r    <= in_data_nxt;
      dropped_r    <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      header_bytes_r <= header_bytes_nxt;
    end
  end

  // Two-entry output queue; head entry may expand into two results
  crsd_pkg::out_entry_t head_r, tail_r;
  logic [1:0]           cnt_r, cnt_nxt;
  logic                 phase_r;
  logic                 push;
  logic                 out_xfer;
  logic                 head_done;

  assign in_ready  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign push      = in_xfer && has_result;
  assign out_xfer  = out_valid && out_ready;
  assign head_done = out_xfer && (phase_r || !head_r.abort);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !head_done)      cnt_nxt = cnt_r + 2'd1;
    else if (!push && head_done) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= 2'd0;
      phase_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (head_done)     phase_r <= 1'b0;
      else if (out_xfer) phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_done) begin
      if (cnt_r == 2'd2) head_r <= tail_r;
      else if (push)     head_r <= new_entry;
      if (push && (cnt_r == 2'd2)) tail_r <= new_entry;
    end else if (push) begin
      if (cnt_r == 2'd0) head_r <= new_entry;
      else               tail_r <= new_entry;
    end
  end

  // Result view of the head entry
  assign out_frame_id  = head_r.hdr.frame_id;
  assign out_extended  = head_r.hdr.extended;
  assign out_dlc       = head_r.hdr.dlc;
  assign out_brs       = head_r.hdr.brs;
  assign out_esi       = head_r.hdr.esi;
  assign out_fd_format = head_r.hdr.fd_format;
  assign out_channel   = head_r.hdr.channel;

  always_comb begin
    if (phase_r) begin
      out_kind       = crsd_pkg::KIND_ABORT;
      out_data_byte  = 8'd0;
      out_byte_index = head_r.abort_index;
      out_last       = 1'b1;
    end else begin
      out_kind       = head_r.kind;
      out_data_byte  = head_r.data_byte;
      out_byte_index = head_r.byte_index;
      out_last       = head_r.last;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int ITEM_TARGET   = 1500;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;

  // One result transfer, field by field
  typedef struct packed {
    logic [1:0]               kind;
    logic [crsd_pkg::ID_W-1:0] frame_id;
    logic                     extended;
    logic [3:0]               dlc;
    logic                     brs;
    logic                     esi;
    logic                     fd_format;
    logic                     channel;
    logic [7:0]               data_byte;
    logic [7:0]               byte_index;
    logic                     last;
  } can_result_t;

  typedef enum int {OFF_NONE, OFF_ALL, OFF_RANDOM} bus_off_mode_e;
  typedef enum int {RX_FULL, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  // Record parser model plus the queue of results it still expects
  class can_record_scoreboard;
    can_result_t want_q[$];
    int          errors;
    logic [7:0]  skip_len;
    logic [7:0]  skip_cnt;
    logic [2:0]  hdr_pos;
    logic [63:0] hdr_bytes;
    logic [7:0]  data_left;
    logic [7:0]  data_pos;
    bit          in_data;
    bit          dropped;

    function new();
      errors   = 0;
      skip_len = crsd_pkg::HEADER_SKIP_RST;
      clear_stream();
    endfunction

    function void clear_stream();
      skip_cnt  = '0;
      hdr_pos   = '0;
      hdr_bytes = '0;
      data_left = '0;
      data_pos  = '0;
      in_data   = 1'b0;
      dropped   = 1'b0;
    endfunction

    function void set_skip(logic [7:0] v);
      skip_len = v;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Smallest CAN FD code whose payload size holds len bytes
    function logic [3:0] fd_code(logic [7:0] len);
      int sizes[7] = '{12, 16, 20, 24, 32, 48, 64};
      if (len <= 8) return len[3:0];
      for (int k = 0; k < 6; k++) begin
        if (len <= sizes[k]) return 4'(9 + k);
      end
      return 4'd15;
    endfunction

    function void push_result(logic [1:0] kind, logic [7:0] data, logic [7:0] index,
                              bit last);
      can_result_t r;
      r.kind       = kind;
      r.frame_id   = hdr_bytes[crsd_pkg::ID_W-1:0];
      r.extended   = hdr_bytes[crsd_pkg::EXT_BIT];
      r.dlc        = fd_code(hdr_bytes[39:32]);
      r.brs        = hdr_bytes[40];
      r.esi        = hdr_bytes[41];
      r.fd_format  = hdr_bytes[42];
      r.channel    = hdr_bytes[48];
      r.data_byte  = data;
      r.byte_index = index;
      r.last       = last;
      want_q.push_back(r);
    endfunction

    // Advance the parser by one accepted payload byte
    function void note_input(logic [7:0] b, bit eop, bit off0, bit off1);
      logic [7:0] len;
      if (skip_cnt < skip_len) begin
        skip_cnt++;
      end else if (in_data) begin
        data_left--;
        if (!dropped) push_result(crsd_pkg::KIND_DATA, b, data_pos, data_left == 0);
        data_pos++;
        if (data_left == 0) in_data = 1'b0;
        // cut inside the data part
        if (eop && in_data && !dropped)
          push_result(crsd_pkg::KIND_ABORT, 8'd0, data_pos, 1'b1);
      end else begin
        if (hdr_pos == 0) hdr_bytes = '0;
        hdr_bytes[hdr_pos*8 +: 8] = b;
        if (hdr_pos != crsd_pkg::HDR_LAST_POS) begin
          hdr_pos++;
        end else begin
          hdr_pos = '0;
          len     = hdr_bytes[39:32];
          case (hdr_bytes[55:48])
            8'd0:    dropped = off0;
            8'd1:    dropped = off1;
            default: dropped = 1'b1;
          endcase
          data_left = len;
          data_pos  = '0;
          in_data   = (len != 0);
          if (!dropped) begin
            push_result(crsd_pkg::KIND_HEADER, 8'd0, 8'd0, len == 0);
            // payload ends right after the header
            if (eop && in_data) push_result(crsd_pkg::KIND_ABORT, 8'd0, 8'd0, 1'b1);
          end
        end
      end
      if (eop) clear_stream();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task cmp_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task check_result(can_result_t got);
      can_result_t want;
      if (want_q.size() == 0) begin
        report("result with nothing expected");
        return;
      end
      want = want_q.pop_front();
      cmp_field("kind", got.kind, want.kind);
      cmp_field("frame_id", got.frame_id, want.frame_id);
      cmp_field("extended", got.extended, want.extended);
      cmp_field("dlc", got.dlc, want.dlc);
      cmp_field("brs", got.brs, want.brs);
      cmp_field("esi", got.esi, want.esi);
      cmp_field("fd_format", got.fd_format, want.fd_format);
      cmp_field("channel", got.channel, want.channel);
      cmp_field("data_byte", got.data_byte, want.data_byte);
      cmp_field("byte_index", got.byte_index, want.byte_index);
      cmp_field("last", got.last, want.last);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_payload_byte;
  logic        in_last_of_payload;
  logic        in_bus_off_zero;
  logic        in_bus_off_one;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_kind;
  logic [28:0] out_frame_id;
  logic        out_extended;
  logic [3:0]  out_dlc;
  logic        out_brs;
  logic        out_esi;
  logic        out_fd_format;
  logic        out_channel;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_byte_index;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  can_record_scoreboard sb = new();
  int          burst_left = 0;
  int          item_count = 0;
  int          idle_cycles = 0;
  rx_mode_e    rx_mode = RX_FULL;
  int          rx_left = 0;
  can_result_t seen;

  can_record_stream_deframer u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_payload_byte    (in_payload_byte),
    .in_last_of_payload (in_last_of_payload),
    .in_bus_off_zero    (in_bus_off_zero),
    .in_bus_off_one     (in_bus_off_one),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_frame_id       (out_frame_id),
    .out_extended       (out_extended),
    .out_dlc            (out_dlc),
    .out_brs            (out_brs),
    .out_esi            (out_esi),
    .out_fd_format      (out_fd_format),
    .out_channel        (out_channel),
    .out_data_byte      (out_data_byte),
    .out_byte_index     (out_byte_index),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: stall pattern changes mode at random intervals
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_FULL:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= $urandom_range(0, 1);
      RX_SPARSE: out_ready <= ($urandom_range(0, 4) == 0);
      default:   out_ready <= (rx_left % 32) < 5;
    endcase
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.kind       = out_kind;
      seen.frame_id   = out_frame_id;
      seen.extended   = out_extended;
      seen.dlc        = out_dlc;
      seen.brs        = out_brs;
      seen.esi        = out_esi;
      seen.fd_format  = out_fd_format;
      seen.channel    = out_channel;
      seen.data_byte  = out_data_byte;
      seen.byte_index = out_byte_index;
      seen.last       = out_last;
      sb.check_result(seen);
    end
  end

  // Watchdog: no transfer on any port for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // One register access: setup cycle, then access until pready
  task automatic cfg_access(bit wr, logic [7:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {crsd_pkg::REG_HEADER_SKIP, 2'b00};
    pwdata  <= {24'd0, wdata};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_skip_reg(logic [7:0] want);
    logic [31:0] rd;
    cfg_access(1'b0, 8'd0, rd);
    if (rd !== {24'd0, want})
      sb.report($sformatf("header_skip read 0x%0h want 0x%0h", rd, want));
  endtask

  // Hold input off until every expected result has drained
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_header_skip(logic [7:0] v);
    logic [31:0] rd;
    wait_drained();
    cfg_access(1'b1, v, rd);
    sb.set_skip(v);
    // the bus idles between the write and the read-back
    @(posedge clk);
    check_skip_reg(v);
  endtask

  // One byte transfer; bursts of random length with random gaps between
  task automatic push_byte(logic [7:0] b, bit eop, bit off0, bit off1);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
    end
    in_valid           <= 1'b1;
    in_payload_byte    <= b;
    in_last_of_payload <= eop;
    in_bus_off_zero    <= off0;
    in_bus_off_one     <= off1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(b, eop, off0, off1);
    burst_left--;
  endtask

  task automatic send_stream(ref logic [7:0] q[$], input bus_off_mode_e mode);
    bit off0;
    bit off1;
    foreach (q[i]) begin
      case (mode)
        OFF_NONE: begin off0 = 1'b0; off1 = 1'b0; end
        OFF_ALL:  begin off0 = 1'b1; off1 = 1'b1; end
        default: begin
          off0 = ($urandom_range(0, 5) == 0);
          off1 = ($urandom_range(0, 5) == 0);
        end
      endcase
      if (mode == OFF_RANDOM && $urandom_range(0, 399) == 0) wait_drained();
      push_byte(q[i], i == q.size() - 1, off0, off1);
    end
  endtask

  task automatic add_record(ref logic [7:0] q[$], input logic [31:0] word,
                            input logic [7:0] len, flags, chan);
    for (int k = 0; k < 4; k++) q.push_back(word[8*k +: 8]);
    q.push_back(len);
    q.push_back(flags);
    q.push_back(chan);
    q.push_back(8'($urandom));
    repeat (len) q.push_back(8'($urandom));
  endtask

  // Lengths cluster on the code boundaries, with a few long records
  function automatic logic [7:0] pick_len();
    int edges[16] = '{0, 8, 9, 12, 13, 16, 17, 20, 21, 24, 25, 32, 33, 48, 49, 64};
    int r;
    r = $urandom_range(0, 19);
    if (r < 8) return 8'(edges[$urandom_range(0, 15)]);
    if (r < 19) return 8'($urandom_range(0, 20));
    return 8'($urandom_range(65, 255));
  endfunction

  task automatic random_payload(logic [7:0] skip);
    logic [7:0] q[$];
    logic [7:0] chan;
    int         cut;
    repeat (skip) q.push_back(8'($urandom));
    repeat ($urandom_range(0, 4)) begin
      chan = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 1));
      add_record(q, $urandom, pick_len(), 8'($urandom), chan);
    end
    // cut the payload short somewhere
    if ($urandom_range(0, 2) == 0 && q.size() > 1) begin
      cut = $urandom_range(1, q.size() - 1);
      q = q[0:cut-1];
    end
    if (q.size() == 0) q.push_back(8'($urandom));
    item_count += q.size();
    send_stream(q, OFF_RANDOM);
  endtask

  initial begin
    logic [7:0] q[$];
    logic [7:0] skip;
    int         phase;
    int         r;

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_payload_byte    <= 8'd0;
    in_last_of_payload <= 1'b0;
    in_bus_off_zero    <= 1'b0;
    in_bus_off_one     <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= 3'd0;
    pwdata             <= 32'd0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_skip_reg(crsd_pkg::HEADER_SKIP_RST);
    set_header_skip(8'd0);

    // all-ones zero-length record, then a record cut after one data byte
    add_record(q, 32'hFFFF_FFFF, 8'd0, 8'hFF, 8'd1);
    q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'h00);
    q.push_back(8'd2);  q.push_back(8'h00); q.push_back(8'h00); q.push_back(8'hFF);
    q.push_back(8'hFF);
    send_stream(q, OFF_NONE);

    // payload ends on the last header byte of a long record
    q.delete();
    add_record(q, 32'h8000_0123, 8'd200, 8'h05, 8'd0);
    q = q[0:7];
    send_stream(q, OFF_NONE);

    // bus-off drop, then a header cut short
    q.delete();
    add_record(q, 32'h1234_5678, 8'd0, 8'h02, 8'd0);
    q.push_back(8'hA5); q.push_back(8'h5A); q.push_back(8'hFF);
    send_stream(q, OFF_ALL);

    // random phases, each with its own skip length
    phase = 0;
    while (item_count < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      case (phase)
        0:       skip = 8'd255;
        1:       skip = 8'd1;
        default: skip = (r < 5) ? 8'($urandom_range(0, 12)) :
                        (r < 7) ? crsd_pkg::HEADER_SKIP_RST :
                        (r < 8) ? 8'($urandom_range(0, 255)) : 8'd0;
      endcase
      set_header_skip(skip);
      repeat ((phase == 0) ? 1 : $urandom_range(1, 4)) random_payload(skip);
      phase++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
